/* sv/tldpw_pkg.sv */
// ----------------------------------------------------------------------------
// Two-level page walker package
// Shared types, widths and codes of the two-level demand page walker.
// ----------------------------------------------------------------------------
package tldpw_pkg;

  localparam int unsigned FrameW   = 8;
  localparam int unsigned Frames   = 1 << FrameW;
  localparam int unsigned NffW     = FrameW + 1;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned Entries  = 1 << IdxW;
  localparam int unsigned SlotW    = FrameW + IdxW;
  localparam int unsigned Slots    = 1 << SlotW;
  localparam int unsigned PidW     = 4;
  localparam int unsigned Procs    = 1 << PidW;
  localparam int unsigned PageW    = 6;
  localparam int unsigned FaultW   = 7;
  localparam int unsigned ProcRefW = 16;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_ACCESS = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_OOM    = 2'd1;
  localparam logic [1:0] STATUS_HALTED = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [PidW-1:0]   pid;
    logic [PageW-1:0]  page;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                l1_fault;
    logic                l2_fault;
    logic [FrameW-1:0]   table_frame;
    logic [FrameW-1:0]   data_frame;
    logic [7:0]          entry_refs;
    logic [FaultW-1:0]   process_faults;
    logic [ProcRefW-1:0] process_refs;
  } res_t;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [7:0]        refs;
  } ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_L1_RD,
    ST_L1_CHK,
    ST_L1_CLR,
    ST_L2_CHK
  } st_e;

endpackage

/* sv/two_level_demand_page_walker.sv */
// ----------------------------------------------------------------------------
// Two-level demand page walker
// Creates processes and walks their two-level page tables, allocating frames
// on demand with a bump allocator and keeping per-entry and per-process counts.
// A create beat, or any beat once halted, is answered from the first-level read;
// an access beat ends at the first-level check when it runs out of frames there,
// and else goes to the second-level check, by way of a clear on a first-level fault.
// The next beat may be accepted in the cycle that the result is shown.
// The pace is set by the single read and write port of each table memory.
// Reset clears the allocator, the halt flag and the per-process counters;
// the table memories hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
module two_level_demand_page_walker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tldpw_pkg::cmd_t  cmd_i,
  output logic             done_o,
  output tldpw_pkg::res_t  res_o
);

  tldpw_pkg::st_e state_q, state_d;

  tldpw_pkg::cmd_t                     cmd_q;
  logic [tldpw_pkg::NffW-1:0]          nff_q, nff_d;
  logic                                halted_q, halted_d;
  logic [tldpw_pkg::FrameW-1:0]        base_q, base_d;
  logic [tldpw_pkg::FrameW-1:0]        tframe_q, tframe_d;
  logic                                l1f_q, l1f_d;
  tldpw_pkg::res_t                     res_q, res_d;
  logic                                done_q, done_d;

  logic [tldpw_pkg::FrameW-1:0]        ptb_q [tldpw_pkg::Procs];
  logic [tldpw_pkg::FaultW-1:0]        fault_q [tldpw_pkg::Procs];
  logic [tldpw_pkg::ProcRefW-1:0]      prefs_q [tldpw_pkg::Procs];
  logic                                ptb_we;
  logic                                cnt_we;
  logic [tldpw_pkg::FaultW-1:0]        fault_wdata;
  logic [tldpw_pkg::ProcRefW-1:0]      prefs_wdata;

  logic [tldpw_pkg::Entries-1:0]       vld_mem [tldpw_pkg::Frames];
  logic                                vld_we;
  logic [tldpw_pkg::FrameW-1:0]        vld_waddr, vld_raddr;
  logic [tldpw_pkg::Entries-1:0]       vld_wdata, vld_rd;

  tldpw_pkg::ent_t                     ent_mem [tldpw_pkg::Slots];
  logic                                ent_we;
  logic [tldpw_pkg::SlotW-1:0]         ent_waddr, ent_raddr;
  tldpw_pkg::ent_t                     ent_wdata, ent_rd;

  logic [tldpw_pkg::IdxW-1:0]          idx1, idx2;
  logic [tldpw_pkg::Entries-1:0]       bit1, bit2, bits2;
  logic                                oom, hit1, hit2;
  logic [tldpw_pkg::FaultW-1:0]        fault_cur, fault_inc;
  logic [tldpw_pkg::ProcRefW-1:0]      prefs_cur, prefs_inc;
  logic [7:0]                          refs_inc;

  assign idx1      = cmd_q.page[tldpw_pkg::PageW-1 -: tldpw_pkg::IdxW];
  assign idx2      = cmd_q.page[tldpw_pkg::IdxW-1:0];
  assign bit1      = tldpw_pkg::Entries'(1) << idx1;
  assign bit2      = tldpw_pkg::Entries'(1) << idx2;
  assign bits2     = l1f_q ? '0 : vld_rd;
  assign oom       = nff_q[tldpw_pkg::NffW-1];
  assign hit1      = |(vld_rd & bit1);
  assign hit2      = |(bits2 & bit2);
  assign fault_cur = fault_q[cmd_q.pid];
  assign prefs_cur = prefs_q[cmd_q.pid];
  assign fault_inc = (&fault_cur) ? fault_cur : fault_cur + tldpw_pkg::FaultW'(1);
  assign prefs_inc = (&prefs_cur) ? prefs_cur : prefs_cur + tldpw_pkg::ProcRefW'(1);
  assign refs_inc  = ent_rd.refs + 8'd1;

  assign busy   = (state_q != tldpw_pkg::ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tldpw_pkg::ST_IDLE: begin
        if (start) begin
          state_d = tldpw_pkg::ST_L1_RD;
        end
      end
      tldpw_pkg::ST_L1_RD: begin
        if (halted_q || cmd_q.opcode == tldpw_pkg::OP_CREATE) begin
          state_d = tldpw_pkg::ST_IDLE;
        end else begin
          state_d = tldpw_pkg::ST_L1_CHK;
        end
      end
      tldpw_pkg::ST_L1_CHK: begin
        priority if (hit1) begin
          state_d = tldpw_pkg::ST_L2_CHK;
        end else if (oom) begin
          state_d = tldpw_pkg::ST_IDLE;
        end else begin
          state_d = tldpw_pkg::ST_L1_CLR;
        end
      end
      tldpw_pkg::ST_L1_CLR: state_d = tldpw_pkg::ST_L2_CHK;
      tldpw_pkg::ST_L2_CHK: state_d = tldpw_pkg::ST_IDLE;
      default:              state_d = tldpw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    nff_d       = nff_q;
    halted_d    = halted_q;
    base_d      = base_q;
    tframe_d    = tframe_q;
    l1f_d       = l1f_q;
    res_d       = '0;
    done_d      = 1'b0;
    ptb_we      = 1'b0;
    cnt_we      = 1'b0;
    fault_wdata = fault_cur;
    prefs_wdata = prefs_cur;
    vld_we      = 1'b0;
    vld_waddr   = base_q;
    vld_wdata   = '0;
    vld_raddr   = base_q;
    ent_we      = 1'b0;
    ent_waddr   = {base_q, idx1};
    ent_wdata   = ent_rd;
    ent_raddr   = {base_q, idx1};
    unique case (state_q)
      tldpw_pkg::ST_IDLE: begin
      end
      tldpw_pkg::ST_L1_RD: begin
        base_d    = ptb_q[cmd_q.pid];
        l1f_d     = 1'b0;
        vld_raddr = ptb_q[cmd_q.pid];
        ent_raddr = {ptb_q[cmd_q.pid], idx1};
        priority if (halted_q) begin
          done_d       = 1'b1;
          res_d.status = tldpw_pkg::STATUS_HALTED;
        end else if (cmd_q.opcode == tldpw_pkg::OP_CREATE) begin
          done_d = 1'b1;
          if (oom) begin
            halted_d     = 1'b1;
            res_d.status = tldpw_pkg::STATUS_OOM;
          end else begin
            nff_d             = nff_q + tldpw_pkg::NffW'(1);
            ptb_we            = 1'b1;
            cnt_we            = 1'b1;
            fault_wdata       = '0;
            prefs_wdata       = '0;
            vld_we            = 1'b1;
            vld_waddr         = nff_q[tldpw_pkg::FrameW-1:0];
            res_d.status      = tldpw_pkg::STATUS_OK;
            res_d.table_frame = nff_q[tldpw_pkg::FrameW-1:0];
          end
        end else begin
        end
      end
      tldpw_pkg::ST_L1_CHK: begin
        priority if (hit1) begin
          ent_we          = 1'b1;
          ent_wdata.frame = ent_rd.frame;
          ent_wdata.refs  = refs_inc;
          tframe_d        = ent_rd.frame;
          vld_raddr       = ent_rd.frame;
          ent_raddr       = {ent_rd.frame, idx2};
        end else if (oom) begin
          halted_d             = 1'b1;
          done_d               = 1'b1;
          res_d.status         = tldpw_pkg::STATUS_OOM;
          res_d.process_faults = fault_cur;
          res_d.process_refs   = prefs_cur;
        end else begin
          ent_we          = 1'b1;
          ent_wdata.frame = nff_q[tldpw_pkg::FrameW-1:0];
          ent_wdata.refs  = 8'd1;
          vld_we          = 1'b1;
          vld_waddr       = base_q;
          vld_wdata       = vld_rd | bit1;
          nff_d           = nff_q + tldpw_pkg::NffW'(1);
          cnt_we          = 1'b1;
          fault_wdata     = fault_inc;
          l1f_d           = 1'b1;
          tframe_d        = nff_q[tldpw_pkg::FrameW-1:0];
        end
      end
      tldpw_pkg::ST_L1_CLR: begin
        vld_we    = 1'b1;
        vld_waddr = tframe_q;
        vld_wdata = '0;
        vld_raddr = tframe_q;
        ent_raddr = {tframe_q, idx2};
      end
      tldpw_pkg::ST_L2_CHK: begin
        done_d            = 1'b1;
        res_d.l1_fault    = l1f_q;
        res_d.table_frame = tframe_q;
        ent_waddr         = {tframe_q, idx2};
        vld_waddr         = tframe_q;
        priority if (hit2) begin
          ent_we               = 1'b1;
          ent_wdata.frame      = ent_rd.frame;
          ent_wdata.refs       = refs_inc;
          cnt_we               = 1'b1;
          prefs_wdata          = prefs_inc;
          res_d.status         = tldpw_pkg::STATUS_OK;
          res_d.data_frame     = ent_rd.frame;
          res_d.entry_refs     = refs_inc;
          res_d.process_faults = fault_cur;
          res_d.process_refs   = prefs_inc;
        end else if (oom) begin
          halted_d             = 1'b1;
          res_d.status         = tldpw_pkg::STATUS_OOM;
          res_d.process_faults = fault_cur;
          res_d.process_refs   = prefs_cur;
        end else begin
          ent_we               = 1'b1;
          ent_wdata.frame      = nff_q[tldpw_pkg::FrameW-1:0];
          ent_wdata.refs       = 8'd1;
          vld_we               = 1'b1;
          vld_wdata            = bits2 | bit2;
          nff_d                = nff_q + tldpw_pkg::NffW'(1);
          cnt_we               = 1'b1;
          fault_wdata          = fault_inc;
          prefs_wdata          = prefs_inc;
          res_d.status         = tldpw_pkg::STATUS_OK;
          res_d.l2_fault       = 1'b1;
          res_d.data_frame     = nff_q[tldpw_pkg::FrameW-1:0];
          res_d.entry_refs     = 8'd1;
          res_d.process_faults = fault_inc;
          res_d.process_refs   = prefs_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tldpw_pkg::ST_IDLE;
      nff_q    <= '0;
      halted_q <= 1'b0;
      done_q   <= 1'b0;
      for (int i = 0; i < tldpw_pkg::Procs; i++) begin
        fault_q[i] <= '0;
        prefs_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      nff_q    <= nff_d;
      halted_q <= halted_d;
      done_q   <= done_d;
      if (cnt_we) begin
        fault_q[cmd_q.pid] <= fault_wdata;
        prefs_q[cmd_q.pid] <= prefs_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
    if (ptb_we) begin
      ptb_q[cmd_q.pid] <= nff_q[tldpw_pkg::FrameW-1:0];
    end
    base_q   <= base_d;
    tframe_q <= tframe_d;
    l1f_q    <= l1f_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
    vld_rd <= vld_mem[vld_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd <= ent_mem[ent_raddr];
  end

endmodule

/* sv/tldpw_checker.sv */
// ----------------------------------------------------------------------------
// Two-level page walker port checker
// Watches the ports of the page walker for handshake and result consistency.
// ----------------------------------------------------------------------------
module tldpw_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input tldpw_pkg::res_t res_o
);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("Walker did not turn busy after an accepted beat.");

  a_busy_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("Walker turned busy without a start.");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("Result shown while the walker is still busy.");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Two results in consecutive cycles.");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != tldpw_pkg::STATUS_OK |->
      res_o.data_frame == '0 && res_o.entry_refs == '0 && !res_o.l2_fault)
    else $error("Failed walk reports a data frame.");

endmodule

bind two_level_demand_page_walker tldpw_checker u_tldpw_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
